[rtl/core/eqidx_pkg.sv]
// Shared types and constants for the equilibrium index finder.
`default_nettype none

package eqidx_pkg;

    // Fixed field widths of the channels
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;

    // One incoming list element
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } eqidx_in_t;

    // One result per list
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               overflow;
    } eqidx_out_t;

    // Controller states
    typedef enum logic [1:0] {
        S_LOAD,
        S_WAIT,
        S_SCAN
    } eqidx_state_t;

endpackage

`default_nettype wire

[rtl/core/eqidx_stream_if.sv]
// Valid/ready stream interface carrying one request payload.
`default_nettype none

interface eqidx_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/equilibrium_index_finder_top.sv]
// Equilibrium index finder: buffers a list, then scans it for the balance point.
//
//  channel | dir | payload                        | request moves
//  --------+-----+--------------------------------+--------------------------------
//  din     | in  | value[31:0] signed, last       | one list element
//  dout    | out | found, index[9:0], overflow    | one result per list
//
// Loading takes one element per cycle; it is stored at the next free address,
// or dropped and flagged as overflow once the memory is full. After the element
// marked last, the block waits until the result register is empty, then scans:
// one memory read per cycle, ending at a balance point or the last element.
// The single read port of the element memory sets the scan rate.
// din is not ready from the last element until the scan ends; a result that
// waits on dout does not stop loading of the next list.
// Reset clears the control state and the sums; the element memory is not cleared.
`default_nettype none

module equilibrium_index_finder_top #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 32
) (
    input  wire            clk,
    input  wire            rst_n,
    eqidx_stream_if.sink   din,
    eqidx_stream_if.source dout
);
    import eqidx_pkg::*;

    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W = (VALUE_BITS + CW + 2 > 64) ? 64 : (VALUE_BITS + CW + 2);

    // Element memory
    logic [VALUE_BITS-1:0] mem [MAX_ELEMENTS];

    eqidx_state_t state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [SUM_W-1:0]      left_reg, left_next;
    logic                  dropped_reg, dropped_next;
    logic [CW-1:0]         issue_reg, issue_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [INDEX_W-1:0]    out_index_reg, out_index_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  in_ready;
    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS+VALUE_W-1:0] in_pad;
    logic [VALUE_BITS-1:0] in_raw;
    logic [SUM_W-1:0]      in_ext;
    logic [SUM_W-1:0]      rd_ext;
    logic [SUM_W-1:0]      rest;
    logic                  balance;
    logic                  last_rd;
    logic [INDEX_W+AW-1:0] idx_pad;

    // Take the low VALUE_BITS bits of the input, read as two's complement
    assign in_pad = {{VALUE_BITS{1'b0}}, din.payload.value};
    assign in_raw = in_pad[VALUE_BITS-1:0];
    assign in_ext = SUM_W'($signed(in_raw));
    assign rd_ext = SUM_W'($signed(rd_data_reg));

    // Balance test: total - x == 2 * left
    assign rest    = total_reg - rd_ext;
    assign balance = (rest == {left_reg[SUM_W-2:0], 1'b0});
    assign last_rd = ((CW'(rd_idx_reg) + CW'(1)) == count_reg);
    assign idx_pad = {{INDEX_W{1'b0}}, rd_idx_reg};

    assign in_ready = (state_reg == S_LOAD);
    assign accept   = din.valid && in_ready;
    assign rd_addr  = issue_reg[AW-1:0];

    assign din.ready            = in_ready;
    assign dout.valid           = out_valid_reg;
    assign dout.payload.found    = out_found_reg;
    assign dout.payload.index    = out_index_reg;
    assign dout.payload.overflow = out_ovf_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        left_next      = left_reg;
        dropped_next   = dropped_reg;
        issue_next     = issue_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        out_ovf_next   = out_ovf_reg;
        wr_en          = 1'b0;

        // Result taken downstream
        if (dout.valid && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg != CW'(MAX_ELEMENTS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        total_next = total_reg + in_ext;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (din.payload.last)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end

            // Hold until the result register is free
            S_WAIT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_SCAN;
                    issue_next = '0;
                    left_next  = '0;
                end
            end

            S_SCAN:
            begin
                // Issue the next read
                if (issue_reg != count_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = rd_addr;
                    issue_next    = issue_reg + CW'(1);
                end

                // Compare the element that came back
                if (rd_valid_reg)
                begin
                    left_next = left_reg + rd_ext;
                    if (balance || last_rd)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = balance;
                        out_index_next = balance ? idx_pad[INDEX_W-1:0] : '0;
                        out_ovf_next   = dropped_reg;
                        count_next     = '0;
                        total_next     = '0;
                        left_next      = '0;
                        dropped_next   = 1'b0;
                        rd_valid_next  = 1'b0;
                        state_next     = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            total_reg     <= '0;
            left_reg      <= '0;
            dropped_reg   <= 1'b0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            left_reg      <= left_next;
            dropped_reg   <= dropped_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Element memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= in_raw;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // A result only appears at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_SCAN))
        else $error("result raised outside a scan");

    // The fill count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    // A scan read only targets stored entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && rd_valid_reg) |-> (CW'(rd_idx_reg) < count_reg))
        else $error("scan read past stored elements");

endmodule

`default_nettype wire
